>>> rtl/kda_pkg.sv
// ----------------------------------------------------------------------------
// kda_pkg
// Shared types, constants and helpers for the keypad debounce and
// auto-repeat event unit.
// ----------------------------------------------------------------------------
package kda_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int CODE_W   = 18;
	localparam int MATRIX_W = 16;
	localparam int DIRECT_W = 2;
	localparam int CMD_W    = 2;
	localparam int KIND_W   = 3;
	localparam int KEY_W    = 5;
	localparam int TICKS_W  = 8;
	localparam int TIME_W   = 16;
	localparam int WAIT_W   = 11;
	localparam int REG_W    = 16;
	localparam int REGIDX_W = 3;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

	localparam logic [KIND_W-1:0] EVT_NONE      = 3'd0;
	localparam logic [KIND_W-1:0] EVT_PRESS     = 3'd1;
	localparam logic [KIND_W-1:0] EVT_UP_PRESS  = 3'd2;
	localparam logic [KIND_W-1:0] EVT_DN_PRESS  = 3'd3;
	localparam logic [KIND_W-1:0] EVT_STEP_REL  = 3'd4;
	localparam logic [KIND_W-1:0] EVT_ENTER_REL = 3'd5;
	localparam logic [KIND_W-1:0] EVT_UP_HOLD   = 3'd6;
	localparam logic [KIND_W-1:0] EVT_DN_HOLD   = 3'd7;

	localparam logic [REGIDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd0;
	localparam logic [REGIDX_W-1:0] REG_HOLD_DELAY     = 3'd1;
	localparam logic [REGIDX_W-1:0] REG_UP_KEY         = 3'd2;
	localparam logic [REGIDX_W-1:0] REG_DOWN_KEY       = 3'd3;
	localparam logic [REGIDX_W-1:0] REG_ENTER_KEY      = 3'd4;
	localparam logic [REGIDX_W-1:0] REG_REPEAT_EN      = 3'd5;
	localparam logic [REGIDX_W-1:0] REG_BEEP_EN        = 3'd6;

	localparam logic [TICKS_W-1:0] RST_DEBOUNCE = 8'd10;
	localparam logic [TIME_W-1:0]  RST_HOLD     = 16'd1000;
	localparam logic [KEY_W-1:0]   RST_UP_KEY   = 5'd2;
	localparam logic [KEY_W-1:0]   RST_DOWN_KEY = 5'd3;
	localparam logic [KEY_W-1:0]   RST_ENTER    = 5'd4;

	localparam logic [TIME_W-1:0] HELD_MAX    = 16'hFFFF;
	localparam logic [TIME_W-1:0] HELD_FAST   = 16'd8000;
	localparam logic [TIME_W-1:0] HELD_QUICK  = 16'd5400;
	localparam logic [TIME_W-1:0] HELD_MEDIUM = 16'd3000;
	localparam logic [WAIT_W-1:0] WAIT_FAST   = 11'd50;
	localparam logic [WAIT_W-1:0] WAIT_QUICK  = 11'd100;
	localparam logic [WAIT_W-1:0] WAIT_MEDIUM = 11'd300;
	localparam logic [WAIT_W-1:0] WAIT_SLOW   = 11'd500;
	localparam logic [WAIT_W-1:0] WAIT_OTHER  = 11'd1000;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CODE_W-1:0] code;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic              qempty;
		logic              beep;
	} result_t;

	typedef struct packed {
		logic                en;
		logic [REGIDX_W-1:0] index;
		logic [REG_W-1:0]    data;
	} cfg_wr_t;

	function automatic logic [KEY_W-1:0] onehot_index(input logic [CODE_W-1:0] code);
		logic [KEY_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < CODE_W; i++) begin
			idx = idx | (code[i] ? KEY_W'(i) : '0);
		end
		return idx;
	endfunction

endpackage

>>> rtl/kda_front.sv
// ----------------------------------------------------------------------------
// kda_front
// Accepts items, forms the 18-bit key code from the sample and holds the
// classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module kda_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [kda_pkg::CMD_W-1:0]      command,
	input  logic [kda_pkg::MATRIX_W-1:0]   matrix_keys,
	input  logic [kda_pkg::DIRECT_W-1:0]   direct_keys,
	output logic                           item_valid,
	output kda_pkg::item_t                 item,
	input  logic                           item_take
);

	kda_pkg::item_t               slot_q [2];
	logic                         wr_q;
	logic                         rd_q;
	logic [1:0]                   cnt_q;
	logic [kda_pkg::MATRIX_W-1:0] lowest;
	kda_pkg::item_t               new_item;
	logic                         do_push;
	logic                         do_pop;

	assign lowest        = matrix_keys & (~matrix_keys + 1'b1);
	assign new_item.cmd  = command;
	assign new_item.code = {lowest, direct_keys};

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = slot_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/kda_back.sv
// ----------------------------------------------------------------------------
// kda_back
// Holds the configuration, runs debounce, hold timing and auto-repeat on
// ticks, and keeps the overwriting event ring for pop and peek.
// ----------------------------------------------------------------------------
module kda_back (
	input  logic              clk,
	input  logic              arst_n,
	input  kda_pkg::cfg_wr_t  cfg_wr,
	input  logic              item_valid,
	input  kda_pkg::item_t    item,
	output logic              item_take,
	input  logic              res_ready,
	output logic              res_valid,
	output kda_pkg::result_t  res
);

	logic [kda_pkg::TICKS_W-1:0] debounce_ticks_q;
	logic [kda_pkg::TIME_W-1:0]  hold_delay_q;
	logic [kda_pkg::KEY_W-1:0]   up_key_q;
	logic [kda_pkg::KEY_W-1:0]   down_key_q;
	logic [kda_pkg::KEY_W-1:0]   enter_key_q;
	logic                        repeat_en_q;
	logic                        beep_en_q;

	logic [kda_pkg::CODE_W-1:0]  latched_q, latched_n;
	logic [kda_pkg::CODE_W-1:0]  accepted_q, accepted_n;
	logic [kda_pkg::TICKS_W-1:0] dcount_q, dcount_n;
	logic [kda_pkg::TIME_W-1:0]  held_q, held_n;
	logic [kda_pkg::WAIT_W-1:0]  rwait_q, rwait_n;
	logic [kda_pkg::QPTR_W-1:0]  rd_q, rd_n;
	logic [kda_pkg::QPTR_W-1:0]  wr_q, wr_n;
	logic [kda_pkg::KIND_W+kda_pkg::KEY_W-1:0] ring_q [kda_pkg::QUEUE_DEPTH];

	logic                        take;
	logic [kda_pkg::TICKS_W-1:0] reload;
	logic [kda_pkg::CODE_W-1:0]  code;
	logic                        code_single;
	logic                        acc_single;
	logic [kda_pkg::KEY_W-1:0]   code_idx;
	logic [kda_pkg::KEY_W-1:0]   acc_idx;
	logic [kda_pkg::KIND_W-1:0]  kind;
	logic [kda_pkg::KEY_W-1:0]   key;
	logic                        beep;
	logic                        qempty;
	logic                        push_evt;
	logic [kda_pkg::QPTR_W-1:0]  wr_inc;
	logic [kda_pkg::QPTR_W-1:0]  rd_inc;
	logic [kda_pkg::KIND_W+kda_pkg::KEY_W-1:0] head;

	assign take      = item_valid && res_ready;
	assign item_take = take;
	assign res_valid = take;
	assign reload    = (debounce_ticks_q == '0) ? kda_pkg::TICKS_W'(1) : debounce_ticks_q;
	assign head      = ring_q[rd_q];
	assign wr_inc    = (wr_q == kda_pkg::QPTR_W'(kda_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
	assign rd_inc    = (rd_q == kda_pkg::QPTR_W'(kda_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;

	assign acc_single = (accepted_q != '0) && ((accepted_q & (accepted_q - 1'b1)) == '0);
	assign acc_idx    = kda_pkg::onehot_index(accepted_q);

	// a judged code never differs from the stored latch: a new sample reloads the count
	assign code = latched_q;

	always_comb begin
		code_single = (code != '0) && ((code & (code - 1'b1)) == '0);
		code_idx    = kda_pkg::onehot_index(code);
	end

	always_comb begin
		latched_n  = latched_q;
		accepted_n = accepted_q;
		dcount_n   = dcount_q;
		held_n     = held_q;
		rwait_n    = rwait_q;
		rd_n       = rd_q;
		wr_n       = wr_q;
		kind       = kda_pkg::EVT_NONE;
		key        = '0;
		beep       = 1'b0;
		qempty     = 1'b0;
		push_evt   = 1'b0;
		if (take) begin
			unique case (item.cmd)
				kda_pkg::CMD_TICK: begin
					if (held_q != kda_pkg::HELD_MAX) begin
						held_n = held_q + 1'b1;
					end
					if (rwait_q != '0) begin
						rwait_n = rwait_q - 1'b1;
					end
					if (dcount_q != '0) begin
						if (latched_q != item.code) begin
							latched_n = item.code;
							dcount_n  = reload;
							if (item.code != '0) begin
								held_n = '0;
							end
						end else begin
							dcount_n = dcount_q - 1'b1;
						end
					end
					if (dcount_n == '0) begin
						dcount_n   = reload;
						accepted_n = latched_n;
						if (latched_n == '0) begin
							if (acc_single) begin
								if (acc_idx == up_key_q || acc_idx == down_key_q) begin
									kind = kda_pkg::EVT_STEP_REL;
									key  = acc_idx;
								end else if (acc_idx == enter_key_q) begin
									kind = kda_pkg::EVT_ENTER_REL;
									key  = acc_idx;
								end
							end
						end else if (accepted_q == '0) begin
							beep = 1'b1;
							if (code_single) begin
								if (code_idx == up_key_q) begin
									kind = kda_pkg::EVT_UP_PRESS;
									key  = code_idx;
								end else if (code_idx == down_key_q) begin
									kind = kda_pkg::EVT_DN_PRESS;
									key  = code_idx;
								end else if (code_idx != enter_key_q) begin
									kind = kda_pkg::EVT_PRESS;
									key  = code_idx;
								end
							end
						end else if (accepted_q == latched_n) begin
							if (held_n > hold_delay_q && rwait_n == '0 && repeat_en_q) begin
								if (code_single &&
								    (code_idx == up_key_q || code_idx == down_key_q)) begin
									beep = 1'b1;
									priority if (held_n > kda_pkg::HELD_FAST) begin
										rwait_n = kda_pkg::WAIT_FAST;
									end else if (held_n > kda_pkg::HELD_QUICK) begin
										rwait_n = kda_pkg::WAIT_QUICK;
									end else if (held_n > kda_pkg::HELD_MEDIUM) begin
										rwait_n = kda_pkg::WAIT_MEDIUM;
									end else begin
										rwait_n = kda_pkg::WAIT_SLOW;
									end
									kind = (code_idx == up_key_q) ? kda_pkg::EVT_UP_HOLD
									                              : kda_pkg::EVT_DN_HOLD;
									key  = code_idx;
								end else begin
									rwait_n = kda_pkg::WAIT_OTHER;
								end
							end
						end
						push_evt = (kind != kda_pkg::EVT_NONE);
					end
				end
				kda_pkg::CMD_POP, kda_pkg::CMD_PEEK: begin
					if (rd_q == wr_q) begin
						qempty = 1'b1;
					end else begin
						kind = head[kda_pkg::KEY_W +: kda_pkg::KIND_W];
						key  = head[kda_pkg::KEY_W-1:0];
						if (item.cmd == kda_pkg::CMD_POP) begin
							rd_n = rd_inc;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (push_evt) begin
			wr_n = wr_inc;
			if (wr_inc == rd_q) begin
				rd_n = rd_inc;
			end
		end
	end

	assign res.kind   = kind;
	assign res.key    = key;
	assign res.qempty = qempty;
	assign res.beep   = beep && beep_en_q;

	always_ff @(posedge clk) begin
		if (push_evt) begin
			ring_q[wr_q] <= {kind, key};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q  <= '0;
			accepted_q <= '0;
			dcount_q   <= '0;
			held_q     <= '0;
			rwait_q    <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
		end else begin
			latched_q  <= latched_n;
			accepted_q <= accepted_n;
			dcount_q   <= dcount_n;
			held_q     <= held_n;
			rwait_q    <= rwait_n;
			rd_q       <= rd_n;
			wr_q       <= wr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= kda_pkg::RST_DEBOUNCE;
			hold_delay_q     <= kda_pkg::RST_HOLD;
			up_key_q         <= kda_pkg::RST_UP_KEY;
			down_key_q       <= kda_pkg::RST_DOWN_KEY;
			enter_key_q      <= kda_pkg::RST_ENTER;
			repeat_en_q      <= 1'b1;
			beep_en_q        <= 1'b1;
		end else if (cfg_wr.en) begin
			unique case (cfg_wr.index)
				kda_pkg::REG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_wr.data[kda_pkg::TICKS_W-1:0];
				kda_pkg::REG_HOLD_DELAY:     hold_delay_q     <= cfg_wr.data[kda_pkg::TIME_W-1:0];
				kda_pkg::REG_UP_KEY:         up_key_q         <= cfg_wr.data[kda_pkg::KEY_W-1:0];
				kda_pkg::REG_DOWN_KEY:       down_key_q       <= cfg_wr.data[kda_pkg::KEY_W-1:0];
				kda_pkg::REG_ENTER_KEY:      enter_key_q      <= cfg_wr.data[kda_pkg::KEY_W-1:0];
				kda_pkg::REG_REPEAT_EN:      repeat_en_q      <= cfg_wr.data[0];
				kda_pkg::REG_BEEP_EN:        beep_en_q        <= cfg_wr.data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/kda_out.sv
// ----------------------------------------------------------------------------
// kda_out
// Two-entry result queue that decouples the back end from the reader.
// ----------------------------------------------------------------------------
module kda_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	input  kda_pkg::result_t              res,
	output logic                          res_ready,
	output logic                          empty,
	input  logic                          pop,
	output logic [kda_pkg::KIND_W-1:0]    event_kind,
	output logic [kda_pkg::KEY_W-1:0]     event_key,
	output logic                          queue_empty,
	output logic                          beep_pulse
);

	kda_pkg::result_t slot_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;
	kda_pkg::result_t head;

	assign res_ready   = (cnt_q != 2'd2);
	assign empty       = (cnt_q == 2'd0);
	assign do_push     = res_valid && res_ready;
	assign do_pop      = pop && !empty;
	assign head        = slot_q[rd_q];
	assign event_kind  = head.kind;
	assign event_key   = head.key;
	assign queue_empty = head.qempty;
	assign beep_pulse  = head.beep;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/keypad_debounce_autorepeat_events_unit.sv
// ----------------------------------------------------------------------------
// keypad_debounce_autorepeat_events_unit
// Keypad debounce with typematic repeat and an overwriting event ring.
//
//   port group                     direction  handshake
//   command/matrix_keys/direct_keys  in        push, full
//   event_kind/event_key/
//     queue_empty/beep_pulse         out       empty, pop
//   wr_index/wr_data                 in        wr_en (no wait)
//
// One item per cycle sustained while the reader pops; a result passes the
// front queue register and the result queue register. Reset is asynchronous,
// clears all control state and loads the configuration defaults; the event
// ring is not cleared and needs no sweep. A stalled reader fills the result
// queue, then the front queue, and full rises; either side resumes at once.
// ----------------------------------------------------------------------------
module keypad_debounce_autorepeat_events_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [kda_pkg::CMD_W-1:0]       command,
	input  logic [kda_pkg::MATRIX_W-1:0]    matrix_keys,
	input  logic [kda_pkg::DIRECT_W-1:0]    direct_keys,
	output logic                            empty,
	input  logic                            pop,
	output logic [kda_pkg::KIND_W-1:0]      event_kind,
	output logic [kda_pkg::KEY_W-1:0]       event_key,
	output logic                            queue_empty,
	output logic                            beep_pulse,
	input  logic                            wr_en,
	input  logic [kda_pkg::REGIDX_W-1:0]    wr_index,
	input  logic [kda_pkg::REG_W-1:0]       wr_data
);

	kda_pkg::item_t   item;
	logic             item_valid;
	logic             item_take;
	kda_pkg::result_t res;
	logic             res_valid;
	logic             res_ready;
	kda_pkg::cfg_wr_t cfg_wr;

	assign cfg_wr.en    = wr_en;
	assign cfg_wr.index = wr_index;
	assign cfg_wr.data  = wr_data;

	kda_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.matrix_keys (matrix_keys),
		.direct_keys (direct_keys),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take)
	);

	kda_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.res        (res)
	);

	kda_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res         (res),
		.res_ready   (res_ready),
		.empty       (empty),
		.pop         (pop),
		.event_kind  (event_kind),
		.event_key   (event_key),
		.queue_empty (queue_empty),
		.beep_pulse  (beep_pulse)
	);

endmodule
